// ----- rtl/shlcg_pkg.sv -----
// Shared types and constants for the shuffled three-generator random source.
// Used by every module of the block; depends on nothing.

package shlcg_pkg;

   // Field widths.
   localparam int SEED_W = 32;
   localparam int GEN_W  = 18;
   localparam int NUM_W  = 36;

   // Width of a value entering a modular reduction; the reciprocal shift equals it.
   localparam int VAL_W     = 34;
   localparam int RED_SHIFT = 34;

   // Generator constants.
   localparam int unsigned MOD1 = 259200;
   localparam int unsigned MUL1 = 7141;
   localparam int unsigned ADD1 = 54773;
   localparam int unsigned MOD2 = 134456;
   localparam int unsigned MUL2 = 8121;
   localparam int unsigned ADD2 = 28411;
   localparam int unsigned MOD3 = 243000;
   localparam int unsigned MUL3 = 4561;
   localparam int unsigned ADD3 = 51349;

   // A multiple of MOD1 added to 54773 - seed so the value is never negative.
   localparam longint unsigned SEED_BIAS = 64'd8286 * 64'd259200;
   localparam longint unsigned SEED_BASE = SEED_BIAS + 64'd54773;

   // Exact division of slot products by MOD3 through a rounded-up reciprocal.
   localparam int SLOT_SHIFT = 44;
   localparam longint unsigned SLOT_RECIP =
      ((64'd1 << SLOT_SHIFT) + 64'd243000 - 64'd1) / 64'd243000;
   localparam int SLOT_RECIP_W = $clog2(SLOT_RECIP + 64'd1);

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;    // latch the seed of an accepted word
      logic reseed;     // the accepted word reseeds
      logic load1;      // load the first generator from the seed
      logic step1;
      logic step2;
      logic step3;
      logic copy2;      // second generator takes the first mod MOD2
      logic copy3;      // third generator takes the first mod MOD3
      logic fill_clr;   // restart the fill pointer
      logic fill_write; // write the pair value at the fill pointer
      logic slot_mul;   // form depth * third generator and the pair value
      logic slot_div;   // divide into a slot index
      logic table_rw;   // read the slot and refill it
      logic out_load;   // load the result register
   } shlcg_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic seed_neg;
      logic gen_done;
      logic fill_last;
      logic out_free;
   } shlcg_stat_type;

endpackage

// ----- rtl/shlcg_lcg.sv -----
// One linear congruential generator with a four-stage modular reduction.
// Depends on shlcg_pkg.

module shlcg_lcg #(
   parameter int unsigned MUL     = 7141,
   parameter int unsigned ADD     = 54773,
   parameter int unsigned MODULUS = 259200
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         step_i,
   input  logic                         load_i,
   input  logic                         set_i,
   input  logic [shlcg_pkg::GEN_W-1:0]  set_value_i,
   input  logic [shlcg_pkg::VAL_W-1:0]  raw_value_i,
   output logic [shlcg_pkg::GEN_W-1:0]  gen_o,
   output logic                         done_o
);

   localparam int VAL_W   = shlcg_pkg::VAL_W;
   localparam int GEN_W   = shlcg_pkg::GEN_W;
   localparam longint unsigned RECIP = (64'd1 << shlcg_pkg::RED_SHIFT) / MODULUS;
   localparam int RECIP_W = $clog2(RECIP + 64'd1);
   localparam int PROD_W  = VAL_W + RECIP_W;

   logic [GEN_W-1:0]   gen_ff, gen_in;
   logic [2:0]         vld_ff;
   logic               done_ff;
   logic [VAL_W-1:0]   v1_ff, v2_ff, v3_ff, v1_in;
   logic [RECIP_W-1:0] q_ff, q_in;
   logic [VAL_W-1:0]   t_ff, t_in;
   logic [PROD_W-1:0]  prod;
   logic [VAL_W-1:0]   diff;
   logic [GEN_W:0]     rem;

   // Stage 1: the affine step, or the raw seed value.
   assign v1_in = load_i ? raw_value_i
                         : VAL_W'(gen_ff) * VAL_W'(MUL) + VAL_W'(ADD);

   // Stage 2: quotient estimate, at most one below the true quotient.
   assign prod = PROD_W'(v1_ff) * PROD_W'(RECIP);
   assign q_in = prod[PROD_W-1:shlcg_pkg::RED_SHIFT];

   // Stage 3: multiple of the modulus to take away.
   assign t_in = VAL_W'(q_ff) * VAL_W'(MODULUS);

   // Stage 4: remainder below twice the modulus, then one correction.
   assign diff = v3_ff - t_ff;
   assign rem  = diff[GEN_W:0];
   always_comb begin
      if (rem >= (GEN_W + 1)'(MODULUS)) begin
         gen_in = GEN_W'(rem - (GEN_W + 1)'(MODULUS));
      end else begin
         gen_in = GEN_W'(rem);
      end
   end

   // Generator state and stage valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         gen_ff  <= '0;
         vld_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         vld_ff  <= {vld_ff[1:0], step_i | load_i};
         done_ff <= vld_ff[2];
         if (vld_ff[2]) begin
            gen_ff <= gen_in;
         end else if (set_i) begin
            gen_ff <= set_value_i;
         end
      end
   end

   // Reduction pipeline payload.
   always_ff @(posedge clock) begin
      v1_ff <= v1_in;
      v2_ff <= v1_ff;
      q_ff  <= q_in;
      v3_ff <= v2_ff;
      t_ff  <= t_in;
   end

   assign gen_o  = gen_ff;
   assign done_o = done_ff;

endmodule

// ----- rtl/shlcg_dpath.sv -----
// Datapath: three generators, the shuffle table memory, slot arithmetic and
// the result register. Depends on shlcg_pkg and shlcg_lcg.

module shlcg_dpath #(
   parameter int TABLE_DEPTH = 97
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [shlcg_pkg::SEED_W-1:0]   seed_i,
   input  shlcg_pkg::shlcg_cmd_type       cmd_i,
   output shlcg_pkg::shlcg_stat_type      stat_o,
   output logic                           rsp_valid_o,
   input  logic                           rsp_ready_i,
   output logic [shlcg_pkg::NUM_W-1:0]    num_o,
   output logic                           reseeded_o,
   output logic [shlcg_pkg::SEED_W-1:0]   seed_out_o
);

   localparam int GEN_W  = shlcg_pkg::GEN_W;
   localparam int VAL_W  = shlcg_pkg::VAL_W;
   localparam int SEED_W = shlcg_pkg::SEED_W;
   localparam int NUM_W  = shlcg_pkg::NUM_W;
   localparam int IDX_W  = $clog2(TABLE_DEPTH);
   localparam int P_W    = GEN_W + $clog2(TABLE_DEPTH);
   localparam int SP_W   = P_W + shlcg_pkg::SLOT_RECIP_W;

   logic [GEN_W-1:0]  g1, g2, g3;
   logic              done1, done2, done3;
   logic [VAL_W-1:0]  raw_seed;
   logic [GEN_W-1:0]  copy2_val, copy3_val;
   logic [NUM_W-1:0]  pair_c;

   logic [SEED_W-1:0] seed_ff;
   logic              re_ff;
   logic [IDX_W-1:0]  fill_idx_ff;
   logic [P_W-1:0]    p_ff;
   logic [NUM_W-1:0]  pair_ff;
   logic [IDX_W-1:0]  slot_ff;
   logic [SP_W-1:0]   slot_prod;
   logic [NUM_W-1:0]  rd_ff;
   logic [NUM_W-1:0]  table_mem [TABLE_DEPTH];
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [NUM_W-1:0]  wr_data;

   logic              rsp_valid_ff;
   logic [NUM_W-1:0]  num_ff;
   logic              reseeded_ff;
   logic [SEED_W-1:0] seed_out_ff;

   // Seed mapped to a non-negative value congruent to 54773 - seed.
   assign raw_seed = VAL_W'(shlcg_pkg::SEED_BASE)
                   - {{(VAL_W - SEED_W){seed_ff[SEED_W-1]}}, seed_ff};

   // First generator reduced into the ranges of the other two.
   assign copy2_val = (g1 >= GEN_W'(shlcg_pkg::MOD2)) ? g1 - GEN_W'(shlcg_pkg::MOD2) : g1;
   assign copy3_val = (g1 >= GEN_W'(shlcg_pkg::MOD3)) ? g1 - GEN_W'(shlcg_pkg::MOD3) : g1;

   // Pair value g1 * MOD2 + g2 as stored in the table.
   assign pair_c = NUM_W'(g1) * NUM_W'(shlcg_pkg::MOD2) + NUM_W'(g2);

   shlcg_lcg #(
      .MUL     (shlcg_pkg::MUL1),
      .ADD     (shlcg_pkg::ADD1),
      .MODULUS (shlcg_pkg::MOD1)
   ) u_gen1 (
      .clock       (clock),
      .reset       (reset),
      .step_i      (cmd_i.step1),
      .load_i      (cmd_i.load1),
      .set_i       (1'b0),
      .set_value_i ('0),
      .raw_value_i (raw_seed),
      .gen_o       (g1),
      .done_o      (done1)
   );

   shlcg_lcg #(
      .MUL     (shlcg_pkg::MUL2),
      .ADD     (shlcg_pkg::ADD2),
      .MODULUS (shlcg_pkg::MOD2)
   ) u_gen2 (
      .clock       (clock),
      .reset       (reset),
      .step_i      (cmd_i.step2),
      .load_i      (1'b0),
      .set_i       (cmd_i.copy2),
      .set_value_i (copy2_val),
      .raw_value_i ('0),
      .gen_o       (g2),
      .done_o      (done2)
   );

   shlcg_lcg #(
      .MUL     (shlcg_pkg::MUL3),
      .ADD     (shlcg_pkg::ADD3),
      .MODULUS (shlcg_pkg::MOD3)
   ) u_gen3 (
      .clock       (clock),
      .reset       (reset),
      .step_i      (cmd_i.step3),
      .load_i      (1'b0),
      .set_i       (cmd_i.copy3),
      .set_value_i (copy3_val),
      .raw_value_i ('0),
      .gen_o       (g3),
      .done_o      (done3)
   );

   // Control registers: fill pointer and result valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd_i.fill_clr) begin
            fill_idx_ff <= '0;
         end else if (cmd_i.fill_write) begin
            fill_idx_ff <= fill_idx_ff + IDX_W'(1);
         end
         if (cmd_i.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready_i) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Word capture and slot arithmetic.
   assign slot_prod = SP_W'(p_ff) * SP_W'(shlcg_pkg::SLOT_RECIP);

   always_ff @(posedge clock) begin
      if (cmd_i.capture) begin
         seed_ff <= seed_i;
         re_ff   <= cmd_i.reseed;
      end
      if (cmd_i.slot_mul) begin
         p_ff    <= P_W'(g3) * P_W'(TABLE_DEPTH);
         pair_ff <= pair_c;
      end
      if (cmd_i.slot_div) begin
         slot_ff <= slot_prod[shlcg_pkg::SLOT_SHIFT +: IDX_W];
      end
   end

   // Shuffle table: one write port, one registered read port.
   assign wr_en   = cmd_i.fill_write | cmd_i.table_rw;
   assign wr_addr = cmd_i.table_rw ? slot_ff : fill_idx_ff;
   assign wr_data = cmd_i.table_rw ? pair_ff : pair_c;

   always_ff @(posedge clock) begin
      if (cmd_i.table_rw) begin
         rd_ff <= table_mem[slot_ff];
      end
      if (wr_en) begin
         table_mem[wr_addr] <= wr_data;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (cmd_i.out_load) begin
         num_ff      <= rd_ff;
         reseeded_ff <= re_ff;
         seed_out_ff <= re_ff ? SEED_W'(1) : seed_ff;
      end
   end

   assign stat_o.seed_neg  = seed_i[SEED_W-1];
   assign stat_o.gen_done  = done1 & done2 | done1 & done3 | done1;
   assign stat_o.fill_last = (fill_idx_ff == IDX_W'(TABLE_DEPTH - 1));
   assign stat_o.out_free  = ~rsp_valid_ff | rsp_ready_i;

   assign rsp_valid_o = rsp_valid_ff;
   assign num_o       = num_ff;
   assign reseeded_o  = reseeded_ff;
   assign seed_out_o  = seed_out_ff;

endmodule

// ----- rtl/shlcg_ctrl.sv -----
// Controller: sequences reseeding, table fill and each draw.
// Depends on shlcg_pkg; drives shlcg_dpath through command and status.

module shlcg_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid_i,
   output logic                       req_ready_o,
   input  shlcg_pkg::shlcg_stat_type  stat_i,
   output shlcg_pkg::shlcg_cmd_type   cmd_o
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEED_WAIT,
      ST_MIX1_WAIT,
      ST_MIX2_WAIT,
      ST_FILL_WAIT,
      ST_DRAW_WAIT,
      ST_SLOT_MUL,
      ST_SLOT_DIV,
      ST_TABLE,
      ST_RESULT
   } state_type;

   state_type                state_ff;
   logic                     ready_ff;
   logic                     seeded_ff;
   shlcg_pkg::shlcg_cmd_type pulse_ff;
   logic                     accept;
   logic                     reseed;

   assign accept = req_valid_i & ready_ff;
   assign reseed = stat_i.seed_neg | ~seeded_ff;

   // State, ready and one-cycle command pulses.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         ready_ff  <= 1'b1;
         seeded_ff <= 1'b0;
         pulse_ff  <= '0;
      end else begin
         pulse_ff <= '0;
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  ready_ff <= 1'b0;
                  if (reseed) begin
                     seeded_ff      <= 1'b1;
                     pulse_ff.load1 <= 1'b1;
                     state_ff       <= ST_SEED_WAIT;
                  end else begin
                     pulse_ff.step1 <= 1'b1;
                     pulse_ff.step2 <= 1'b1;
                     pulse_ff.step3 <= 1'b1;
                     state_ff       <= ST_DRAW_WAIT;
                  end
               end
            end
            ST_SEED_WAIT: begin
               if (stat_i.gen_done) begin
                  pulse_ff.step1 <= 1'b1;
                  state_ff       <= ST_MIX1_WAIT;
               end
            end
            ST_MIX1_WAIT: begin
               if (stat_i.gen_done) begin
                  pulse_ff.copy2 <= 1'b1;
                  pulse_ff.step1 <= 1'b1;
                  state_ff       <= ST_MIX2_WAIT;
               end
            end
            ST_MIX2_WAIT: begin
               if (stat_i.gen_done) begin
                  pulse_ff.copy3    <= 1'b1;
                  pulse_ff.fill_clr <= 1'b1;
                  pulse_ff.step1    <= 1'b1;
                  pulse_ff.step2    <= 1'b1;
                  state_ff          <= ST_FILL_WAIT;
               end
            end
            ST_FILL_WAIT: begin
               // Write this slot and start the next step, or the draw after the last.
               if (stat_i.gen_done) begin
                  pulse_ff.fill_write <= 1'b1;
                  pulse_ff.step1      <= 1'b1;
                  pulse_ff.step2      <= 1'b1;
                  if (stat_i.fill_last) begin
                     pulse_ff.step3 <= 1'b1;
                     state_ff       <= ST_DRAW_WAIT;
                  end
               end
            end
            ST_DRAW_WAIT: begin
               if (stat_i.gen_done) begin
                  pulse_ff.slot_mul <= 1'b1;
                  state_ff          <= ST_SLOT_MUL;
               end
            end
            ST_SLOT_MUL: begin
               pulse_ff.slot_div <= 1'b1;
               state_ff          <= ST_SLOT_DIV;
            end
            ST_SLOT_DIV: begin
               pulse_ff.table_rw <= 1'b1;
               state_ff          <= ST_TABLE;
            end
            ST_TABLE: begin
               state_ff <= ST_RESULT;
            end
            ST_RESULT: begin
               if (stat_i.out_free) begin
                  ready_ff <= 1'b1;
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               ready_ff <= 1'b1;
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // Capture and result load follow the handshakes directly.
   always_comb begin
      cmd_o          = pulse_ff;
      cmd_o.capture  = accept;
      cmd_o.reseed   = reseed;
      cmd_o.out_load = (state_ff == ST_RESULT) & stat_i.out_free;
   end

   assign req_ready_o = ready_ff;

endmodule

// ----- rtl/shuffled_three_lcg_random_top.sv -----
// Top level of the shuffled three-generator uniform random source.
// Depends on shlcg_pkg, shlcg_ctrl, shlcg_dpath and shlcg_lcg.
//
// Usage:
// Each word on the req_ channel carries a signed seed and yields exactly one
// word on the rsp_ channel. A negative seed, or the first word after reset,
// reseeds the three generators and refills the shuffle table before the draw.
// Every generator step runs through a four-stage modular reduction pipeline,
// and the controller waits for it before it starts the next step. The next
// word is accepted the cycle after the result is loaded. A reseed adds the
// seed load, the two mixing steps and the table fill before the draw, one
// table slot per generator step.
// Reset is synchronous; it clears the generators and the seeded flag, so the
// first word always reseeds. The table needs no clearing.
// The result sits in an output register: while the receiver stalls, the
// block still accepts and works on the next word, and waits only when that
// next result is ready and the register is still full.

module shuffled_three_lcg_random_top #(
   parameter int TABLE_DEPTH = 97
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] seed
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [35:0] sample_numerator, [67:36] seed_out, zero pad
   output logic        rsp_tuser    // [0] reseeded
);

   shlcg_pkg::shlcg_cmd_type            cmd;
   shlcg_pkg::shlcg_stat_type           stat;
   logic [shlcg_pkg::NUM_W-1:0]         num;
   logic [shlcg_pkg::SEED_W-1:0]        seed_out;
   logic                                reseeded;

   shlcg_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid_i (req_tvalid),
      .req_ready_o (req_tready),
      .stat_i      (stat),
      .cmd_o       (cmd)
   );

   shlcg_dpath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .seed_i      (req_tdata),
      .cmd_i       (cmd),
      .stat_o      (stat),
      .rsp_valid_o (rsp_tvalid),
      .rsp_ready_i (rsp_tready),
      .num_o       (num),
      .reseeded_o  (reseeded),
      .seed_out_o  (seed_out)
   );

   // Result word packing.
   assign rsp_tdata = {4'b0000, seed_out, num};
   assign rsp_tuser = reseeded;

endmodule

// ----- tb/sv/shuffled_three_lcg_random_top_tb.sv -----
`timescale 1ns / 100ps
// Testbench for shuffled_three_lcg_random_top: sends signed seed words, predicts every draw
// with its own copy of the three generators and the shuffle table, and checks each result.
// Depends on shlcg_pkg and the RTL of the block.

module shuffled_three_lcg_random_top_tb;

   localparam int GEN_W        = shlcg_pkg::GEN_W;
   localparam int NUM_W        = shlcg_pkg::NUM_W;
   localparam int SEED_W       = shlcg_pkg::SEED_W;
   localparam int DEPTH        = 97;
   localparam int RANDOM_WORDS = 1000;
   localparam int QUIET_LIMIT  = 6000;
   localparam int MAX_REPORTS  = 40;

   typedef longint unsigned u64_type;

   // One expected result word.
   typedef struct packed {
      logic [NUM_W-1:0]  numerator;
      logic [SEED_W-1:0] seed_out;
      logic              reseeded;
   } draw_word_type;

   // Tracks the generator state, predicts each draw and checks the result words in order.
   class draw_tracker;
      localparam int unsigned G1_MOD = 259200;
      localparam int unsigned G1_MUL = 7141;
      localparam int unsigned G1_INC = 54773;
      localparam int unsigned G2_MOD = 134456;
      localparam int unsigned G2_MUL = 8121;
      localparam int unsigned G2_INC = 28411;
      localparam int unsigned G3_MOD = 243000;
      localparam int unsigned G3_MUL = 4561;
      localparam int unsigned G3_INC = 51349;

      logic [GEN_W-1:0] gen1, gen2, gen3;
      logic [NUM_W-1:0] slots[256];
      bit               primed;
      int               depth;
      draw_word_type    waiting[$];
      int               checked;
      int               reseeds;
      int               failures;

      function new(int table_depth);
         depth    = table_depth;
         gen1     = '0;
         gen2     = '0;
         gen3     = '0;
         primed   = 1'b0;
         checked  = 0;
         reseeds  = 0;
         failures = 0;
      endfunction

      function logic [GEN_W-1:0] advance(logic [GEN_W-1:0] x, u64_type mul, u64_type inc,
                                         u64_type modulus);
         return GEN_W'((u64_type'(x) * mul + inc) % modulus);
      endfunction

      function logic [NUM_W-1:0] pair_sample();
         return NUM_W'(u64_type'(gen1) * G2_MOD + gen2);
      endfunction

      // Reload all three generators from the seed and refill every slot.
      function void restart(logic signed [SEED_W-1:0] seed);
         longint offset;
         // Floored remainder, so seeds above the increment still land in range.
         offset = (longint'(G1_INC) - longint'(seed)) % longint'(G1_MOD);
         if (offset < 0) offset += longint'(G1_MOD);
         gen1 = GEN_W'(offset);
         gen1 = advance(gen1, G1_MUL, G1_INC, G1_MOD);
         gen2 = GEN_W'(gen1 % G2_MOD);
         gen1 = advance(gen1, G1_MUL, G1_INC, G1_MOD);
         gen3 = GEN_W'(gen1 % G3_MOD);
         for (int k = 0; k < depth; k++) begin
            gen1     = advance(gen1, G1_MUL, G1_INC, G1_MOD);
            gen2     = advance(gen2, G2_MUL, G2_INC, G2_MOD);
            slots[k] = pair_sample();
         end
      endfunction

      // Predict the result of one accepted seed word.
      function void note_seed(logic [SEED_W-1:0] word);
         draw_word_type want;
         bit            fresh;
         int            slot;
         fresh = word[SEED_W-1] || !primed;
         if (fresh) begin
            restart(word);
            primed = 1'b1;
            reseeds++;
         end
         gen1 = advance(gen1, G1_MUL, G1_INC, G1_MOD);
         gen2 = advance(gen2, G2_MUL, G2_INC, G2_MOD);
         gen3 = advance(gen3, G3_MUL, G3_INC, G3_MOD);
         slot = int'((u64_type'(depth) * gen3) / G3_MOD);
         want.numerator = slots[slot];
         slots[slot]    = pair_sample();
         want.reseeded  = fresh;
         want.seed_out  = fresh ? SEED_W'(1) : word;
         waiting.push_back(want);
      endfunction

      function int pending();
         return waiting.size();
      endfunction

      task report_mismatch(string what, u64_type got, u64_type want);
         failures++;
         if (failures <= MAX_REPORTS)
            $display("draw %0d: %s is 0x%0h, expected 0x%0h", checked, what, got, want);
      endtask

      // Compare one result word with the oldest prediction.
      task check_draw(logic [71:0] data, logic flag);
         draw_word_type want;
         if (waiting.size() == 0) begin
            report_mismatch("word with no draw pending, numerator", data[35:0], 0);
            return;
         end
         want = waiting.pop_front();
         checked++;
         if (data[35:0] !== want.numerator)
            report_mismatch("sample_numerator", data[35:0], want.numerator);
         if (data[67:36] !== want.seed_out)
            report_mismatch("seed_out", data[67:36], want.seed_out);
         if (flag !== want.reseeded)
            report_mismatch("reseeded", flag, want.reseeded);
         if (data[71:68] !== 4'd0)
            report_mismatch("padding", data[71:68], 0);
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;    // [31:0] seed
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;    // [35:0] sample_numerator, [67:36] seed_out, zero pad
   logic        rsp_tuser;    // [0] reseeded

   draw_tracker tracker;
   bit          steady;
   int          quiet_cycles;

   shuffled_three_lcg_random_top #(.TABLE_DEPTH(DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #4 clock = ~clock;

   // Gap lengths: mostly none or short, a few long, none at all in steady stretches.
   function automatic int pick_gap();
      int roll;
      if (steady) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Offer one seed word and wait for it to be taken; then idle or wait for all results.
   task automatic send_seed(input logic [31:0] seed, input bit drain);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= seed;
      do @(posedge clock); while (!req_tready);
      if (drain) begin
         req_tvalid <= 1'b0;
         while (tracker.pending() != 0) @(posedge clock);
      end else begin
         gap = pick_gap();
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            req_tdata  <= $urandom;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Observe both channels at the clock edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) tracker.note_seed(req_tdata);
         if (rsp_tvalid && rsp_tready) tracker.check_draw(rsp_tdata, rsp_tuser);
      end
   end

   // Watchdog on stretches in which neither channel moves a word.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles < QUIET_LIMIT) begin
         quiet_cycles <= quiet_cycles + 1;
      end else begin
         $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
         $display("shuffled_three_lcg_random_top_tb NOT OK");
         $finish;
      end
   end

   // Receiver: ready runs broken by stalls of random length.
   initial begin : receiver
      int run;
      int stall;
      rsp_tready = 1'b0;
      @(posedge clock);
      forever begin
         run   = $urandom_range(1, 24);
         stall = pick_gap();
         rsp_tready <= 1'b1;
         repeat (run) @(posedge clock);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      logic [31:0] directed[$];
      logic [31:0] seed;
      int          roll;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      steady       = 1'b0;
      tracker      = new(DEPTH);
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // The first word reseeds even though positive, here with the largest seed.
      // Then ignored positive seeds, the negative extremes, a seed whose offset is
      // a whole modulus, back-to-back reseeds and alternating bit patterns.
      directed = '{32'h7FFF_FFFF, 32'd0, 32'd54773, 32'd1, 32'hFFFF_FFFF, 32'd12,
                   32'h8000_0001, 32'h8000_0000, 32'd3, -32'sd204427, -32'sd259200,
                   32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h5555_5555, 32'h2AAA_AAAA, 32'd54772,
                   -32'sd54773, 32'd99};
      foreach (directed[i]) send_seed(directed[i], i == directed.size() - 1);

      // Random seeds: mostly plain draws, with occasional reseeds.
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n % 64 == 0) steady = ($urandom_range(0, 3) == 0);
         roll = $urandom_range(0, 99);
         if (roll < 3)       seed = $urandom | 32'h8000_0000;
         else if (roll < 6)  seed = -$urandom_range(1, 300000);
         else if (roll < 50) seed = $urandom_range(0, 54773);
         else                seed = $urandom & 32'h7FFF_FFFF;
         send_seed(seed, (n == RANDOM_WORDS - 1) || ($urandom_range(0, 199) == 0));
      end

      // Let any late word surface before the verdict.
      repeat (30) @(posedge clock);
      $display("Checked %0d draws, %0d of them reseeding, from extreme and random seeds.",
               tracker.checked, tracker.reseeds);
      if (tracker.failures == 0 && tracker.pending() == 0)
         $display("shuffled_three_lcg_random_top_tb OK");
      else
         $display("shuffled_three_lcg_random_top_tb NOT OK");
      $finish;
   end

endmodule
